[hdl/abode_pkg.sv]
package abode_pkg;

   // default build constants
   localparam int MAX_ORDER_DEF = 5;
   localparam int FRAC_BITS_DEF = 32;
   localparam int EXP_TERMS     = 16;
   localparam int ORDER_W       = 3;

   localparam logic [63:0] LN2_Q64 = 64'hB172_17F7_D1CF_79AB;
   localparam logic [63:0] ONE62   = 64'h4000_0000_0000_0000;
   localparam logic [63:0] SMAX    = 64'h7FFF_FFFF_FFFF_FFFF;
   localparam logic [63:0] SMIN    = 64'h8000_0000_0000_0000;
   localparam logic [63:0] ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;

   typedef logic [ORDER_W-1:0] order_type;
   typedef logic [1:0]         status_type;
   typedef logic [1:0]         reg_index_type;

   // result status codes
   localparam status_type ST_OK    = 2'd0;
   localparam status_type ST_SHORT = 2'd1;
   localparam status_type ST_SAT   = 2'd2;

   // register indexes
   localparam reg_index_type REG_ORDER = 2'd0;
   localparam reg_index_type REG_STEP  = 2'd1;
   localparam reg_index_type REG_START = 2'd2;

   typedef enum logic [4:0] {
      S_IDLE,
      S_TERM,
      S_TERM_R,
      S_PMUL,
      S_PMUL_R,
      S_PDIV_R,
      S_SLOPE,
      S_SLOPE_R,
      S_EXPK,
      S_HMUL,
      S_HMUL_R,
      S_HDIV_R,
      S_EXPF,
      S_TMUL,
      S_TMUL_R,
      S_YMUL_R,
      S_MWAIT,
      S_DWAIT,
      S_DIV,
      S_DQUO,
      S_DFIX,
      S_DONE
   } state_type;

   typedef struct packed {
      logic        ov;
      logic [63:0] val;
   } sat_type;

   typedef struct packed {
      logic        neg;
      logic [11:0] mag;
   } coef_type;

   // adams-bashforth weights, newest slope first
   function automatic coef_type coef(input order_type m, input logic [2:0] j);
      coef_type c;
      c = '{neg: 1'b0, mag: 12'd0};
      case ({m, j})
         {3'd2, 3'd0}: c = '{neg: 1'b0, mag: 12'd3};
         {3'd2, 3'd1}: c = '{neg: 1'b1, mag: 12'd1};
         {3'd3, 3'd0}: c = '{neg: 1'b0, mag: 12'd23};
         {3'd3, 3'd1}: c = '{neg: 1'b1, mag: 12'd16};
         {3'd3, 3'd2}: c = '{neg: 1'b0, mag: 12'd5};
         {3'd4, 3'd0}: c = '{neg: 1'b0, mag: 12'd55};
         {3'd4, 3'd1}: c = '{neg: 1'b1, mag: 12'd59};
         {3'd4, 3'd2}: c = '{neg: 1'b0, mag: 12'd37};
         {3'd4, 3'd3}: c = '{neg: 1'b1, mag: 12'd9};
         {3'd5, 3'd0}: c = '{neg: 1'b0, mag: 12'd1901};
         {3'd5, 3'd1}: c = '{neg: 1'b1, mag: 12'd2774};
         {3'd5, 3'd2}: c = '{neg: 1'b0, mag: 12'd2616};
         {3'd5, 3'd3}: c = '{neg: 1'b1, mag: 12'd1274};
         {3'd5, 3'd4}: c = '{neg: 1'b0, mag: 12'd251};
         default:      c = '{neg: 1'b0, mag: 12'd0};
      endcase
      return c;
   endfunction

   // common denominator of each weight set
   function automatic logic [9:0] den(input order_type m);
      logic [9:0] d;
      case (m)
         3'd2:    d = 10'd2;
         3'd3:    d = 10'd12;
         3'd4:    d = 10'd24;
         3'd5:    d = 10'd720;
         default: d = 10'd2;
      endcase
      return d;
   endfunction

   // floor((2^64 - 1) / d) for each weight denominator
   function automatic logic [63:0] den_recip(input order_type m);
      logic [63:0] r;
      case (m)
         3'd2:    r = ALL_ONES / 64'd2;
         3'd3:    r = ALL_ONES / 64'd12;
         3'd4:    r = ALL_ONES / 64'd24;
         3'd5:    r = ALL_ONES / 64'd720;
         default: r = ALL_ONES / 64'd2;
      endcase
      return r;
   endfunction

   // floor((2^64 - 1) / n) for each series term number
   function automatic logic [63:0] term_recip(input logic [4:0] n);
      logic [63:0] r;
      case (n)
         5'd2:    r = ALL_ONES / 64'd2;
         5'd3:    r = ALL_ONES / 64'd3;
         5'd4:    r = ALL_ONES / 64'd4;
         5'd5:    r = ALL_ONES / 64'd5;
         5'd6:    r = ALL_ONES / 64'd6;
         5'd7:    r = ALL_ONES / 64'd7;
         5'd8:    r = ALL_ONES / 64'd8;
         5'd9:    r = ALL_ONES / 64'd9;
         5'd10:   r = ALL_ONES / 64'd10;
         5'd11:   r = ALL_ONES / 64'd11;
         5'd12:   r = ALL_ONES / 64'd12;
         5'd13:   r = ALL_ONES / 64'd13;
         5'd14:   r = ALL_ONES / 64'd14;
         5'd15:   r = ALL_ONES / 64'd15;
         5'd16:   r = ALL_ONES / 64'd16;
         default: r = ALL_ONES;
      endcase
      return r;
   endfunction

   function automatic logic [63:0] magnitude(input logic [63:0] a);
      return a[63] ? 64'd0 - a : a;
   endfunction

   // signed result of a magnitude product, saturated to 64 bits
   function automatic sat_type sat_mul(input logic [127:0] q, input logic neg);
      sat_type    r;
      logic [63:0] lim;
      lim   = neg ? SMIN : SMAX;
      r.ov  = (q[127:64] != 64'd0) || (q[63:0] > lim);
      r.val = r.ov ? (neg ? SMIN : SMAX) : (neg ? 64'd0 - q[63:0] : q[63:0]);
      return r;
   endfunction

   function automatic sat_type add_sat(input logic [63:0] a, input logic [63:0] b);
      sat_type    r;
      logic [64:0] s;
      s     = {a[63], a} + {b[63], b};
      r.ov  = s[64] != s[63];
      r.val = r.ov ? (s[64] ? SMIN : SMAX) : s[63:0];
      return r;
   endfunction

   function automatic sat_type sub_sat(input logic [63:0] a, input logic [63:0] b);
      sat_type    r;
      logic [64:0] s;
      s     = {a[63], a} - {b[63], b};
      r.ov  = s[64] != s[63];
      r.val = r.ov ? (s[64] ? SMIN : SMAX) : s[63:0];
      return r;
   endfunction

endpackage

[hdl/abode_if.sv]
// input word channel
interface abode_req_if;
   logic        valid;
   logic        ready;
   logic        mode;
   logic [63:0] load_value;
   modport source (output valid, mode, load_value, input ready);
   modport sink (input valid, mode, load_value, output ready);
endinterface

// result word channel
interface abode_rsp_if;
   logic        valid;
   logic        ready;
   logic [63:0] new_value;
   logic [63:0] value_time;
   logic [1:0]  status;
   modport source (output valid, new_value, value_time, status, input ready);
   modport sink (input valid, new_value, value_time, status, output ready);
endinterface

// register write channel
interface abode_csr_if;
   logic        valid;
   logic        ready;
   logic [1:0]  index;
   logic [63:0] data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

[hdl/abode_mul.sv]
// 64 x 64 unsigned multiplier, one 32 x 32 partial product per cycle
module abode_mul (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   input  logic [63:0]  a,
   input  logic [63:0]  b,
   output logic         done,
   output logic [127:0] prod
);

   logic         run_ff, run_in;
   logic [1:0]   cnt_ff, cnt_in;
   logic [63:0]  a_ff, a_in, b_ff, b_in;
   logic [63:0]  pp_ff, pp_in;
   logic [1:0]   pos_ff, pos_in;
   logic         pv_ff, pv_in, last_ff, last_in, done_ff, done_in;
   logic [127:0] acc_ff, acc_in;
   logic [31:0]  ah, bh;

   // half selection for the current partial product
   assign ah = cnt_ff[1] ? a_ff[63:32] : a_ff[31:0];
   assign bh = cnt_ff[0] ? b_ff[63:32] : b_ff[31:0];

   always_comb begin
      run_in  = run_ff;
      cnt_in  = cnt_ff;
      a_in    = a_ff;
      b_in    = b_ff;
      pp_in   = pp_ff;
      pos_in  = pos_ff;
      pv_in   = 1'b0;
      last_in = 1'b0;
      acc_in  = acc_ff;
      done_in = 1'b0;
      // accumulate the registered partial product
      if (pv_ff) begin
         acc_in  = acc_ff + ({64'd0, pp_ff} << {pos_ff, 5'd0});
         done_in = last_ff;
      end
      if (start) begin
         a_in   = a;
         b_in   = b;
         run_in = 1'b1;
         cnt_in = 2'd0;
         acc_in = 128'd0;
      end else if (run_ff) begin
         pp_in   = ah * bh;
         pos_in  = {1'b0, cnt_ff[1]} + {1'b0, cnt_ff[0]};
         pv_in   = 1'b1;
         last_in = cnt_ff == 2'd3;
         cnt_in  = cnt_ff + 2'd1;
         if (cnt_ff == 2'd3) begin
            run_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         pv_ff   <= 1'b0;
         last_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= 2'd0;
      end else begin
         run_ff  <= run_in;
         pv_ff   <= pv_in;
         last_ff <= last_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      a_ff   <= a_in;
      b_ff   <= b_in;
      pp_ff  <= pp_in;
      pos_ff <= pos_in;
      acc_ff <= acc_in;
   end

   assign done = done_ff;
   assign prod = acc_ff;

endmodule

[hdl/abode_div.sv]
// quotient fix-up after a reciprocal multiply: the estimate is at most one low,
// remainder taken from the back product, then compare and subtract until done
module abode_div (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] num,
   input  logic [63:0] den,
   input  logic [63:0] q_est,
   input  logic [63:0] q_den,
   output logic        done,
   output logic [63:0] quo,
   output logic [63:0] rem
);

   logic        run_ff, run_in, done_ff, done_in;
   logic [63:0] quo_ff, quo_in, rem_ff, rem_in, den_ff, den_in;

   always_comb begin
      run_in  = run_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      done_in = 1'b0;
      if (start) begin
         quo_in = q_est;
         rem_in = num - q_den;
         den_in = den;
         run_in = 1'b1;
      end else if (run_ff) begin
         // one more divisor fits: bump the quotient
         if (rem_ff >= den_ff) begin
            rem_in = rem_ff - den_ff;
            quo_in = quo_ff + 64'd1;
         end else begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign done = done_ff;
   assign quo  = quo_ff;
   assign rem  = rem_ff;

endmodule

[hdl/adams_bashforth_ode_stepper_unit.sv]
// channel   dir   handshake       payload
// req_ch    in    valid / ready   mode, load_value
// rsp_ch    out   valid / ready   new_value, value_time, status
// csr_ch    in    valid / ready   index, data (ready always high)
//
// one word at a time; a step does the weighted slope sum and its division first
// most of the work is in the exp series: 16 horner terms, each a product and a
// division by the term number on the one shared multiplier
// a division is a reciprocal product, a back product and a fix-up
// a step with too short a history goes straight to the done state and answers
// reset: registers to defaults, history empty
// a finished result waits in the output register; a following word runs and
// holds in its last state until that register is free
module adams_bashforth_ode_stepper_unit #(
   parameter int MAX_ORDER = abode_pkg::MAX_ORDER_DEF,
   parameter int FRAC_BITS = abode_pkg::FRAC_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   abode_req_if.sink   req_ch,
   abode_rsp_if.source rsp_ch,
   abode_csr_if.sink   csr_ch
);

   localparam int HW        = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1;
   localparam int EXP_SHIFT = 62 - FRAC_BITS;
   localparam logic [63:0] LN2_Q =
      ((abode_pkg::LN2_Q64 >> (63 - FRAC_BITS)) + 64'd1) >> 1;
   localparam logic [63:0] LN2_RECIP = abode_pkg::ALL_ONES / LN2_Q;

   abode_pkg::state_type  state_ff, state_in, ret_ff, ret_in, dret_ff, dret_in;
   abode_pkg::order_type  order_ff, order_in, fill_ff, fill_in, m_eff;
   logic [32:0]           hstep_ff, hstep_in;
   logic [63:0]           start_ff, start_in, latest_ff, latest_in;
   logic [63:0]           vh_ff [MAX_ORDER];
   logic [63:0]           vh_in [MAX_ORDER];
   logic [63:0]           sl_ff [MAX_ORDER];
   logic [63:0]           sl_in [MAX_ORDER];
   logic                  short_ff, short_in, ov_ff, ov_in;
   logic                  neg_ff, neg_in, zneg_ff, zneg_in;
   logic [63:0]           t_ff, t_in, v_ff, v_in, acc_ff, acc_in;
   logic [63:0]           k_ff, k_in, r62_ff, r62_in, p_ff, p_in;
   logic [63:0]           dnum_ff, dnum_in, dden_ff, dden_in;
   logic [63:0]           drec_ff, drec_in, dq_ff, dq_in;
   logic [4:0]            n_ff, n_in;
   logic [2:0]            j_ff, j_in;
   logic                  out_valid_ff, out_valid_in;
   logic [63:0]           out_value_ff, out_value_in, out_time_ff, out_time_in;
   abode_pkg::status_type out_status_ff, out_status_in;

   logic                  mul_start, mul_done, div_start, div_done;
   logic [63:0]           mul_a, mul_b, div_num, div_den, div_quo, div_rem;
   logic [63:0]           div_q, div_qd;
   logic [127:0]          mul_prod;
   logic [63:0]           h64;
   logic [HW-1:0]         hidx;

   abode_mul u_mul (
      .clock (clock),
      .reset (reset),
      .start (mul_start),
      .a     (mul_a),
      .b     (mul_b),
      .done  (mul_done),
      .prod  (mul_prod)
   );

   abode_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .q_est (div_q),
      .q_den (div_qd),
      .done  (div_done),
      .quo   (div_quo),
      .rem   (div_rem)
   );

   // effective order and newest-first history index
   assign m_eff = (order_ff < 3'd2) ? 3'd2 :
                  (order_ff > abode_pkg::order_type'(MAX_ORDER)) ?
                  abode_pkg::order_type'(MAX_ORDER) : order_ff;
   assign hidx  = HW'(MAX_ORDER - 1 - int'(j_ff));
   assign h64   = {31'd0, hstep_ff};

   always_comb begin
      abode_pkg::sat_type  ra, rb;
      abode_pkg::coef_type c;
      logic [63:0]         s, q;
      state_in      = state_ff;
      ret_in        = ret_ff;
      dret_in       = dret_ff;
      order_in      = order_ff;
      hstep_in      = hstep_ff;
      start_in      = start_ff;
      latest_in     = latest_ff;
      fill_in       = fill_ff;
      vh_in         = vh_ff;
      sl_in         = sl_ff;
      short_in      = short_ff;
      ov_in         = ov_ff;
      neg_in        = neg_ff;
      zneg_in       = zneg_ff;
      t_in          = t_ff;
      v_in          = v_ff;
      acc_in        = acc_ff;
      k_in          = k_ff;
      r62_in        = r62_ff;
      p_in          = p_ff;
      dnum_in       = dnum_ff;
      dden_in       = dden_ff;
      drec_in       = drec_ff;
      dq_in         = dq_ff;
      n_in          = n_ff;
      j_in          = j_ff;
      out_valid_in  = out_valid_ff;
      out_value_in  = out_value_ff;
      out_time_in   = out_time_ff;
      out_status_in = out_status_ff;
      mul_start     = 1'b0;
      mul_a         = 64'd0;
      mul_b         = 64'd0;
      div_start     = 1'b0;
      div_num       = 64'd0;
      div_den       = 64'd1;
      div_q         = 64'd0;
      div_qd        = 64'd0;
      ra            = '0;
      rb            = '0;
      c             = abode_pkg::coef(m_eff, j_ff);
      s             = 64'd0;
      q             = 64'd0;

      // output register empties on a taken word
      if (rsp_ch.ready) begin
         out_valid_in = 1'b0;
      end

      case (state_ff)
         abode_pkg::S_IDLE: begin
            if (req_ch.valid) begin
               v_in     = req_ch.load_value;
               ov_in    = 1'b0;
               short_in = 1'b0;
               if (!req_ch.mode) begin
                  ra = abode_pkg::add_sat(latest_ff, h64);
                  if (fill_ff == 3'd0) begin
                     t_in = start_ff;
                  end else begin
                     t_in  = ra.val;
                     ov_in = ra.ov;
                  end
                  state_in = abode_pkg::S_SLOPE;
               end else if (fill_ff < m_eff) begin
                  short_in = 1'b1;
                  state_in = abode_pkg::S_DONE;
               end else begin
                  acc_in   = 64'd0;
                  j_in     = 3'd0;
                  state_in = abode_pkg::S_TERM;
               end
            end
         end
         // weighted slope sum
         abode_pkg::S_TERM: begin
            mul_start = 1'b1;
            mul_a     = {52'd0, c.mag};
            mul_b     = abode_pkg::magnitude(sl_ff[hidx]);
            neg_in    = c.neg ^ sl_ff[hidx][63];
            ret_in    = abode_pkg::S_TERM_R;
            state_in  = abode_pkg::S_MWAIT;
         end
         abode_pkg::S_TERM_R: begin
            ra     = abode_pkg::sat_mul(mul_prod, neg_ff);
            rb     = abode_pkg::add_sat(acc_ff, ra.val);
            acc_in = rb.val;
            ov_in  = ov_ff | ra.ov | rb.ov;
            j_in   = j_ff + 3'd1;
            if (3'(j_ff + 3'd1) == m_eff) begin
               state_in = abode_pkg::S_PMUL;
            end else begin
               state_in = abode_pkg::S_TERM;
            end
         end
         abode_pkg::S_PMUL: begin
            mul_start = 1'b1;
            mul_a     = abode_pkg::magnitude(acc_ff);
            mul_b     = h64;
            neg_in    = acc_ff[63];
            ret_in    = abode_pkg::S_PMUL_R;
            state_in  = abode_pkg::S_MWAIT;
         end
         abode_pkg::S_PMUL_R: begin
            ra       = abode_pkg::sat_mul(mul_prod >> FRAC_BITS, neg_ff);
            ov_in    = ov_ff | ra.ov;
            neg_in   = ra.val[63];
            dnum_in  = abode_pkg::magnitude(ra.val);
            dden_in  = {54'd0, abode_pkg::den(m_eff)};
            drec_in  = abode_pkg::den_recip(m_eff);
            dret_in  = abode_pkg::S_PDIV_R;
            state_in = abode_pkg::S_DIV;
         end
         abode_pkg::S_PDIV_R: begin
            q        = neg_ff ? 64'd0 - div_quo : div_quo;
            ra       = abode_pkg::add_sat(vh_ff[MAX_ORDER-1], q);
            rb       = abode_pkg::add_sat(latest_ff, h64);
            v_in     = ra.val;
            t_in     = rb.val;
            ov_in    = ov_ff | ra.ov | rb.ov;
            state_in = abode_pkg::S_SLOPE;
         end
         // slope: 3t first
         abode_pkg::S_SLOPE: begin
            mul_start = 1'b1;
            mul_a     = abode_pkg::magnitude(t_ff);
            mul_b     = 64'd3;
            neg_in    = t_ff[63];
            ret_in    = abode_pkg::S_SLOPE_R;
            state_in  = abode_pkg::S_MWAIT;
         end
         // range reduction by ln 2
         abode_pkg::S_SLOPE_R: begin
            ra       = abode_pkg::sat_mul(mul_prod, neg_ff);
            ov_in    = ov_ff | ra.ov;
            zneg_in  = ra.val[63];
            dnum_in  = ra.val[63] ? ~ra.val : ra.val;
            dden_in  = LN2_Q;
            drec_in  = LN2_RECIP;
            dret_in  = abode_pkg::S_EXPK;
            state_in = abode_pkg::S_DIV;
         end
         abode_pkg::S_EXPK: begin
            k_in     = zneg_ff ? ~div_quo : div_quo;
            s        = zneg_ff ? LN2_Q - 64'd1 - div_rem : div_rem;
            r62_in   = s << EXP_SHIFT;
            p_in     = abode_pkg::ONE62;
            n_in     = 5'(abode_pkg::EXP_TERMS);
            state_in = abode_pkg::S_HMUL;
         end
         // horner term: p = 1 + (r * p) / n
         abode_pkg::S_HMUL: begin
            mul_start = 1'b1;
            mul_a     = r62_ff;
            mul_b     = p_ff;
            ret_in    = abode_pkg::S_HMUL_R;
            state_in  = abode_pkg::S_MWAIT;
         end
         abode_pkg::S_HMUL_R: begin
            dnum_in  = mul_prod[125:62];
            dden_in  = {59'd0, n_ff};
            drec_in  = abode_pkg::term_recip(n_ff);
            dret_in  = abode_pkg::S_HDIV_R;
            state_in = abode_pkg::S_DIV;
         end
         abode_pkg::S_HDIV_R: begin
            p_in = abode_pkg::ONE62 + div_quo;
            n_in = n_ff - 5'd1;
            if (n_ff == 5'd1) begin
               state_in = abode_pkg::S_EXPF;
            end else begin
               state_in = abode_pkg::S_HMUL;
            end
         end
         // scale by 2^k into the output format
         abode_pkg::S_EXPF: begin
            s = k_ff - 64'(EXP_SHIFT);
            if ($signed(s) > 64'sd0) begin
               acc_in = abode_pkg::SMAX;
               ov_in  = 1'b1;
            end else if (s == 64'd0) begin
               acc_in = p_ff;
            end else if ($signed(s) <= -64'sd64) begin
               acc_in = 64'd0;
            end else begin
               acc_in = p_ff >> 6'(64'd0 - s);
            end
            state_in = abode_pkg::S_TMUL;
         end
         abode_pkg::S_TMUL: begin
            mul_start = 1'b1;
            mul_a     = abode_pkg::magnitude(t_ff);
            mul_b     = abode_pkg::magnitude(acc_ff);
            neg_in    = t_ff[63] ^ acc_ff[63];
            ret_in    = abode_pkg::S_TMUL_R;
            state_in  = abode_pkg::S_MWAIT;
         end
         abode_pkg::S_TMUL_R: begin
            ra        = abode_pkg::sat_mul(mul_prod >> FRAC_BITS, neg_ff);
            acc_in    = ra.val;
            ov_in     = ov_ff | ra.ov;
            mul_start = 1'b1;
            mul_a     = abode_pkg::magnitude(v_ff);
            mul_b     = 64'd2;
            neg_in    = v_ff[63];
            ret_in    = abode_pkg::S_YMUL_R;
            state_in  = abode_pkg::S_MWAIT;
         end
         // slope done, shift into history
         abode_pkg::S_YMUL_R: begin
            ra    = abode_pkg::sat_mul(mul_prod, neg_ff);
            rb    = abode_pkg::sub_sat(acc_ff, ra.val);
            ov_in = ov_ff | ra.ov | rb.ov;
            for (int i = 0; i < MAX_ORDER - 1; i++) begin
               vh_in[i] = vh_ff[i+1];
               sl_in[i] = sl_ff[i+1];
            end
            vh_in[MAX_ORDER-1] = v_ff;
            sl_in[MAX_ORDER-1] = rb.val;
            latest_in          = t_ff;
            if (fill_ff < abode_pkg::order_type'(MAX_ORDER)) begin
               fill_in = fill_ff + 3'd1;
            end
            state_in = abode_pkg::S_DONE;
         end
         // division: quotient estimate from the reciprocal
         abode_pkg::S_DIV: begin
            mul_start = 1'b1;
            mul_a     = dnum_ff;
            mul_b     = drec_ff;
            ret_in    = abode_pkg::S_DQUO;
            state_in  = abode_pkg::S_MWAIT;
         end
         // back product of the estimate
         abode_pkg::S_DQUO: begin
            dq_in     = mul_prod[127:64];
            mul_start = 1'b1;
            mul_a     = mul_prod[127:64];
            mul_b     = dden_ff;
            ret_in    = abode_pkg::S_DFIX;
            state_in  = abode_pkg::S_MWAIT;
         end
         // remainder and final quotient
         abode_pkg::S_DFIX: begin
            div_start = 1'b1;
            div_num   = dnum_ff;
            div_den   = dden_ff;
            div_q     = dq_ff;
            div_qd    = mul_prod[63:0];
            ret_in    = dret_ff;
            state_in  = abode_pkg::S_DWAIT;
         end
         abode_pkg::S_MWAIT: begin
            if (mul_done) begin
               state_in = ret_ff;
            end
         end
         abode_pkg::S_DWAIT: begin
            if (div_done) begin
               state_in = ret_ff;
            end
         end
         abode_pkg::S_DONE: begin
            if (!out_valid_ff || rsp_ch.ready) begin
               out_valid_in = 1'b1;
               if (short_ff) begin
                  out_value_in  = 64'd0;
                  out_time_in   = 64'd0;
                  out_status_in = abode_pkg::ST_SHORT;
               end else begin
                  out_value_in  = v_ff;
                  out_time_in   = t_ff;
                  out_status_in = ov_ff ? abode_pkg::ST_SAT : abode_pkg::ST_OK;
               end
               state_in = abode_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = abode_pkg::S_IDLE;
         end
      endcase

      // register writes
      if (csr_ch.valid) begin
         case (csr_ch.index)
            abode_pkg::REG_ORDER: order_in = csr_ch.data[2:0];
            abode_pkg::REG_STEP:  hstep_in = csr_ch.data[32:0];
            abode_pkg::REG_START: begin
               start_in = csr_ch.data;
               fill_in  = 3'd0;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= abode_pkg::S_IDLE;
         ret_ff       <= abode_pkg::S_IDLE;
         dret_ff      <= abode_pkg::S_IDLE;
         order_ff     <= 3'd4;
         hstep_ff     <= 33'd429496730;
         start_ff     <= 64'd0;
         latest_ff    <= 64'd0;
         fill_ff      <= 3'd0;
         out_valid_ff <= 1'b0;
         for (int i = 0; i < MAX_ORDER; i++) begin
            vh_ff[i] <= 64'd0;
            sl_ff[i] <= 64'd0;
         end
      end else begin
         state_ff     <= state_in;
         ret_ff       <= ret_in;
         dret_ff      <= dret_in;
         order_ff     <= order_in;
         hstep_ff     <= hstep_in;
         start_ff     <= start_in;
         latest_ff    <= latest_in;
         fill_ff      <= fill_in;
         out_valid_ff <= out_valid_in;
         vh_ff        <= vh_in;
         sl_ff        <= sl_in;
      end
      short_ff      <= short_in;
      ov_ff         <= ov_in;
      neg_ff        <= neg_in;
      zneg_ff       <= zneg_in;
      t_ff          <= t_in;
      v_ff          <= v_in;
      acc_ff        <= acc_in;
      k_ff          <= k_in;
      r62_ff        <= r62_in;
      p_ff          <= p_in;
      dnum_ff       <= dnum_in;
      dden_ff       <= dden_in;
      drec_ff       <= drec_in;
      dq_ff         <= dq_in;
      n_ff          <= n_in;
      j_ff          <= j_in;
      out_value_ff  <= out_value_in;
      out_time_ff   <= out_time_in;
      out_status_ff <= out_status_in;
   end

   // channel outputs
   assign req_ch.ready      = state_ff == abode_pkg::S_IDLE;
   assign csr_ch.ready      = 1'b1;
   assign rsp_ch.valid      = out_valid_ff;
   assign rsp_ch.new_value  = out_value_ff;
   assign rsp_ch.value_time = out_time_ff;
   assign rsp_ch.status     = out_status_ff;

endmodule

[hdl/abode_chk.sv]
module abode_chk (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [63:0] rsp_new_value,
   input logic [63:0] rsp_value_time,
   input logic [1:0]  rsp_status
);

   // a result word stays offered until taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result word dropped while stalled");

   // one word at a time
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("input taken while busy");

   // status code in range
   a_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_status != 2'd3)
      else $error("undefined status code");

   // short history answers with zeros
   a_short: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == abode_pkg::ST_SHORT |->
      rsp_new_value == 64'd0 && rsp_value_time == 64'd0)
      else $error("short history result not zero");

endmodule

bind adams_bashforth_ode_stepper_unit abode_chk u_abode_chk (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_ch.valid),
   .req_ready      (req_ch.ready),
   .rsp_valid      (rsp_ch.valid),
   .rsp_ready      (rsp_ch.ready),
   .rsp_new_value  (rsp_ch.new_value),
   .rsp_value_time (rsp_ch.value_time),
   .rsp_status     (rsp_ch.status)
);

[sim/adams_bashforth_ode_stepper_unit_test.sv]
module adams_bashforth_ode_stepper_unit_test;

   timeunit 1ns;
   timeprecision 1ps;

   localparam abode_pkg::reg_index_type REG_SPARE = 2'd3;
   localparam int HIST_DEPTH = abode_pkg::MAX_ORDER_DEF;
   localparam int QUIET_LIMIT = 40000;
   localparam int ITEM_GOAL = 1450;

   typedef struct {
      logic [63:0]           new_value;
      logic [63:0]           value_time;
      abode_pkg::status_type status;
   } ab_result_type;

   // ode integrator shadow and pending result store
   class ab_scoreboard;
      abode_pkg::order_type order_reg;
      logic [32:0]   step_reg;
      longint        start_reg;
      longint        val_hist[HIST_DEPTH];
      longint        slope_hist[HIST_DEPTH];
      longint        last_time;
      int            fill;
      bit            sat_seen;
      int            errors;
      ab_result_type pending_words[$];
      int            weight[4][5] = '{'{3, -1, 0, 0, 0}, '{23, -16, 5, 0, 0},
                                      '{55, -59, 37, -9, 0},
                                      '{1901, -2774, 2616, -1274, 251}};
      longint        divisor[4] = '{2, 12, 24, 720};

      function new();
         order_reg = 3'd4;
         step_reg  = 33'd429496730;
         start_reg = 0;
         last_time = 0;
         fill      = 0;
         errors    = 0;
         foreach (val_hist[i]) begin
            val_hist[i]   = 0;
            slope_hist[i] = 0;
         end
      endfunction

      // fixed-point product of magnitudes, shifted and saturated
      function longint fx_mul(longint a, longint b, int sh);
         bit          neg;
         logic [63:0] ua, ub, lim;
         logic [127:0] pr;
         neg = (a < 0) != (b < 0);
         ua  = a[63] ? 64'd0 - a : a;
         ub  = b[63] ? 64'd0 - b : b;
         pr  = {64'd0, ua} * {64'd0, ub};
         pr  = pr >> sh;
         lim = neg ? abode_pkg::SMIN : abode_pkg::SMAX;
         if (pr[127:64] != 64'd0 || pr[63:0] > lim) begin
            sat_seen = 1;
            return neg ? abode_pkg::SMIN : abode_pkg::SMAX;
         end
         return neg ? 64'd0 - pr[63:0] : pr[63:0];
      endfunction

      function longint fx_add(longint a, longint b);
         logic [64:0] s;
         s = {a[63], a} + {b[63], b};
         if (s[64] != s[63]) begin
            sat_seen = 1;
            return s[64] ? abode_pkg::SMIN : abode_pkg::SMAX;
         end
         return s[63:0];
      endfunction

      function longint fx_sub(longint a, longint b);
         logic [64:0] s;
         s = {a[63], a} - {b[63], b};
         if (s[64] != s[63]) begin
            sat_seen = 1;
            return s[64] ? abode_pkg::SMIN : abode_pkg::SMAX;
         end
         return s[63:0];
      endfunction

      // exp by ln2 range reduction and a horner series in q2.62
      function longint fx_exp(longint z);
         logic [63:0]  ln2w, r, r62, p;
         logic [127:0] pr;
         longint       ln2, k, s;
         ln2w = ((abode_pkg::LN2_Q64 >> 31) + 64'd1) >> 1;
         ln2  = ln2w;
         if (z >= 0) k = z / ln2;
         else k = -((-(z + 1)) / ln2) - 1;
         r   = z - k * ln2;
         r62 = r << 30;
         p   = abode_pkg::ONE62;
         for (int n = abode_pkg::EXP_TERMS; n >= 1; n--) begin
            pr = {64'd0, r62} * {64'd0, p};
            p  = abode_pkg::ONE62 + pr[125:62] / 64'(n);
         end
         s = k - 30;
         if (s > 0) begin
            sat_seen = 1;
            return abode_pkg::SMAX;
         end
         if (s == 0) return p;
         if (s <= -64) return 0;
         return p >> (-s);
      endfunction

      // y' = t * exp(3t) - 2y
      function longint slope(longint t, longint y);
         longint e, a;
         e = fx_exp(fx_mul(t, 3, 0));
         a = fx_mul(t, e, 32);
         return fx_sub(a, fx_mul(y, 2, 0));
      endfunction

      function void push(longint v, longint t);
         longint f;
         f = slope(t, v);
         for (int i = 0; i < HIST_DEPTH - 1; i++) begin
            val_hist[i]   = val_hist[i+1];
            slope_hist[i] = slope_hist[i+1];
         end
         val_hist[HIST_DEPTH-1]   = v;
         slope_hist[HIST_DEPTH-1] = f;
         last_time = t;
         if (fill < HIST_DEPTH) fill++;
      endfunction

      function void write_reg(abode_pkg::reg_index_type idx, logic [63:0] data);
         case (idx)
            abode_pkg::REG_ORDER: order_reg = data[2:0];
            abode_pkg::REG_STEP:  step_reg = data[32:0];
            abode_pkg::REG_START: begin
               start_reg = data;
               fill = 0;
            end
            default: ;
         endcase
      endfunction

      // note an accepted input word and work out its result
      function void note_input(logic mode, logic [63:0] load_value);
         ab_result_type res;
         longint        h, v, t, acc, pv;
         int            m;
         sat_seen = 0;
         h = {31'd0, step_reg};
         if (mode == 1'b0) begin
            v = load_value;
            t = (fill == 0) ? start_reg : fx_add(last_time, h);
            push(v, t);
         end else begin
            m = order_reg;
            if (m < 2) m = 2;
            if (m > HIST_DEPTH) m = HIST_DEPTH;
            if (fill < m) begin
               res = '{64'd0, 64'd0, abode_pkg::ST_SHORT};
               pending_words.push_back(res);
               return;
            end
            acc = 0;
            for (int j = 0; j < m; j++)
               acc = fx_add(acc, fx_mul(weight[m-2][j], slope_hist[HIST_DEPTH-1-j], 0));
            pv = fx_mul(acc, h, 32) / divisor[m-2];
            v  = fx_add(val_hist[HIST_DEPTH-1], pv);
            t  = fx_add(last_time, h);
            push(v, t);
         end
         res.new_value  = v;
         res.value_time = t;
         res.status     = sat_seen ? abode_pkg::ST_SAT : abode_pkg::ST_OK;
         pending_words.push_back(res);
      endfunction

      // compare a result word with the oldest pending one
      function void check_result(logic [63:0] nv, logic [63:0] vt,
                                 abode_pkg::status_type st);
         ab_result_type exp_w;
         if (pending_words.size() == 0) begin
            $display("%0t: unexpected result word value=%h time=%h status=%0d",
                     $realtime, nv, vt, st);
            errors++;
            return;
         end
         exp_w = pending_words.pop_front();
         if (nv !== exp_w.new_value) begin
            $display("%0t: new_value expected %h actual %h", $realtime, exp_w.new_value, nv);
            errors++;
         end
         if (vt !== exp_w.value_time) begin
            $display("%0t: value_time expected %h actual %h", $realtime, exp_w.value_time, vt);
            errors++;
         end
         if (st !== exp_w.status) begin
            $display("%0t: status expected %0d actual %0d", $realtime, exp_w.status, st);
            errors++;
         end
      endfunction
   endclass

   logic clock;
   logic reset;
   bit   calm;
   int   items_sent;
   int   quiet_cycles;
   ab_scoreboard sb;

   abode_req_if req_ch();
   abode_rsp_if rsp_ch();
   abode_csr_if csr_ch();

   adams_bashforth_ode_stepper_unit u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   initial clock = 1'b0;
   always #2 clock = ~clock;

   // result side back-pressure
   always @(posedge clock) begin
      rsp_ch.ready <= calm ? 1'b1 : ($urandom_range(99) >= 37);
   end

   // result check and watchdog
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_ch.valid && rsp_ch.ready)
            sb.check_result(rsp_ch.new_value, rsp_ch.value_time, rsp_ch.status);
         if ((rsp_ch.valid && rsp_ch.ready) || (req_ch.valid && req_ch.ready)
             || (csr_ch.valid && csr_ch.ready))
            quiet_cycles <= 0;
         else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("%0t: watchdog expired", $realtime);
            $display("DONE: errors detected");
            $finish;
         end else
            quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic wait_idle();
      while (sb.pending_words.size() != 0) @(posedge clock);
   endtask

   // register write, only with nothing in flight
   task automatic write_reg(abode_pkg::reg_index_type idx, logic [63:0] data);
      req_ch.valid <= 1'b0;
      wait_idle();
      csr_ch.index <= idx;
      csr_ch.data  <= data;
      csr_ch.valid <= 1'b1;
      do @(posedge clock); while (!(csr_ch.valid && csr_ch.ready));
      sb.write_reg(idx, data);
      csr_ch.valid <= 1'b0;
      @(posedge clock);
   endtask

   // send one input word with a random gap in front
   task automatic send_word(logic mode, logic [63:0] value);
      int gap;
      gap = 0;
      if (!calm)
         while ($urandom_range(99) < 37) gap++;
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.mode       <= mode;
      req_ch.load_value <= value;
      req_ch.valid      <= 1'b1;
      do @(posedge clock); while (!(req_ch.valid && req_ch.ready));
      sb.note_input(mode, value);
      items_sent++;
   endtask

   function automatic logic [63:0] rand_value();
      logic [63:0] w;
      case ($urandom_range(9))
         0: w = abode_pkg::SMAX;
         1: w = abode_pkg::SMIN;
         2, 3: w = {$urandom, $urandom};
         default: w = {28'd0, 4'($urandom_range(15)), $urandom} - (64'd8 << 32);
      endcase
      return w;
   endfunction

   function automatic logic [63:0] rand_step();
      case ($urandom_range(5))
         0: return 64'd1;
         1: return 64'h1_0000_0000;
         2: return {31'd0, 1'($urandom_range(1)), $urandom};
         default: return {32'd0, 2'b00, 30'($urandom_range(32'h3FFF_FFFF))};
      endcase
   endfunction

   function automatic logic [63:0] rand_start();
      case ($urandom_range(7))
         0: return abode_pkg::SMAX;
         1: return abode_pkg::SMIN;
         2: return {$urandom, $urandom};
         default: return {30'd0, 2'($urandom_range(3)), $urandom} - (64'd2 << 32);
      endcase
   endfunction

   initial begin
      int n_load, n_step, phase;
      sb = new();
      calm         = 1'b0;
      items_sent   = 0;
      quiet_cycles = 0;
      reset             <= 1'b1;
      req_ch.valid      <= 1'b0;
      req_ch.mode       <= 1'b0;
      req_ch.load_value <= 64'd0;
      csr_ch.valid      <= 1'b0;
      csr_ch.index      <= abode_pkg::REG_ORDER;
      csr_ch.data       <= 64'd0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: short history, orders, value and time extremes
      send_word(1'b1, 64'd0);
      write_reg(abode_pkg::REG_ORDER, 64'd2);
      send_word(1'b0, 64'd0);
      send_word(1'b1, 64'd0);
      send_word(1'b0, 64'h1_0000_0000);
      send_word(1'b1, 64'd0);
      send_word(1'b1, abode_pkg::SMAX);
      write_reg(abode_pkg::REG_START, abode_pkg::SMAX);
      write_reg(abode_pkg::REG_STEP, 64'h1_0000_0000);
      send_word(1'b0, abode_pkg::SMAX);
      send_word(1'b0, abode_pkg::SMIN);
      send_word(1'b1, 64'd0);
      write_reg(abode_pkg::REG_START, abode_pkg::SMIN);
      write_reg(abode_pkg::REG_STEP, 64'd1);
      write_reg(abode_pkg::REG_ORDER, 64'd7);
      send_word(1'b0, abode_pkg::SMIN);
      send_word(1'b0, 64'hFFFF_FFFF_FFFF_FFFF);
      send_word(1'b0, abode_pkg::SMAX);
      send_word(1'b0, 64'h5_0000_0000);
      send_word(1'b0, 64'hAAAA_5555_AAAA_5555);
      send_word(1'b0, 64'h5555_AAAA_5555_AAAA);
      send_word(1'b1, 64'd0);
      write_reg(REG_SPARE, abode_pkg::SMAX);
      write_reg(abode_pkg::REG_ORDER, 64'd0);
      send_word(1'b1, 64'd0);
      write_reg(abode_pkg::REG_ORDER, 64'd1);
      send_word(1'b1, 64'd0);
      write_reg(abode_pkg::REG_ORDER, 64'd3);
      write_reg(abode_pkg::REG_START, 64'hFFFF_FFFF_8000_0000);
      write_reg(abode_pkg::REG_STEP, 64'h0000_0000_1000_0000);
      send_word(1'b0, 64'd0);
      send_word(1'b0, 64'h0000_0000_8000_0000);
      send_word(1'b0, 64'hFFFF_FFFF_0000_0000);
      send_word(1'b1, 64'd0);

      // random runs: new settings, a few loads, then steps
      phase = 0;
      while (items_sent < ITEM_GOAL) begin
         calm = (phase >= 60 && phase < 80);
         if ($urandom_range(1))
            write_reg(abode_pkg::REG_ORDER, {61'd0, 3'($urandom_range(7))});
         if ($urandom_range(1)) write_reg(abode_pkg::REG_STEP, rand_step());
         if ($urandom_range(3) != 0) write_reg(abode_pkg::REG_START, rand_start());
         if ($urandom_range(15) == 0) write_reg(REG_SPARE, {$urandom, $urandom});
         n_load = ($urandom_range(9) == 0) ? $urandom_range(2) : $urandom_range(5, 6);
         n_step = $urandom_range(1, 10);
         repeat (n_load) send_word(1'b0, rand_value());
         repeat (n_step) begin
            if ($urandom_range(19) == 0) send_word(1'b0, rand_value());
            else send_word(1'b1, {$urandom, $urandom});
         end
         phase++;
      end
      req_ch.valid <= 1'b0;

      // drain and let the block settle
      wait_idle();
      repeat (200) @(posedge clock);
      if (sb.errors == 0 && sb.pending_words.size() == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end
endmodule
